// File: src/urb_pkg.sv
// Shared types and constants for the UART register block.
// No dependencies; imported by every module of the block.
package urb_pkg;

	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 24;
	localparam int unsigned ACT_W      = 2;
	localparam int unsigned BYTE_W     = 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_STEP  = 2'd2
	} action_t;

	// register offsets
	localparam logic [2:0] OFF_RBR = 3'd0;
	localparam logic [2:0] OFF_IER = 3'd1;
	localparam logic [2:0] OFF_IIR = 3'd2;
	localparam logic [2:0] OFF_LCR = 3'd3;
	localparam logic [2:0] OFF_MCR = 3'd4;
	localparam logic [2:0] OFF_LSR = 3'd5;
	localparam logic [2:0] OFF_MSR = 3'd6;
	localparam logic [2:0] OFF_SCR = 3'd7;

	// interrupt identification codes
	localparam logic [2:0] ID_NONE = 3'd1;
	localparam logic [2:0] ID_TX   = 3'd2;
	localparam logic [2:0] ID_RX   = 3'd4;

	localparam logic [6:0] LSR_FIXED = 7'b0110000; // bits 7..1 of line status
	localparam logic [7:0] MSR_FIXED = 8'hB0;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

// File: src/uart_register_block.sv
// Top level: 8250-style UART register file with receive and transmit cell-chain FIFOs.
// Depends on urb_pkg and urb_fifo.
// The result of each accepted input transfer is registered in the output register.
// Throughput: one item per cycle; the output register takes a new result whenever it is
// empty or being drained in the same cycle, so only output backpressure slows the block.
// Reset (arst_n low, asynchronous): architectural registers, FIFO counts and the output valid clear;
// FIFO cell contents are not cleared and are never read before being written.
module uart_register_block #(
	parameter int unsigned RX_DEPTH = 16,
	parameter int unsigned TX_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [2:0] reg_offset, [10:3] write_data, [11] chip_select, [12] rx_valid,
	// [20:13] rx_byte, [23:21] zero
	input  logic [urb_pkg::IN_DATA_W-1:0]    s_tdata,
	// [1:0] action
	input  logic [urb_pkg::ACT_W-1:0]        s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] read_data, [8] irq_pulse, [9] tx_valid, [17:10] tx_byte, [23:18] zero
	output logic [urb_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import urb_pkg::*;

	// input fields
	action_t     act;
	logic [2:0]  reg_offset;
	logic [7:0]  write_data;
	logic        chip_select;
	logic        rx_valid;
	logic [7:0]  rx_byte;
	logic        accept;

	assign act         = action_t'(s_tuser);
	assign reg_offset  = s_tdata[2:0];
	assign write_data  = s_tdata[10:3];
	assign chip_select = s_tdata[11];
	assign rx_valid    = s_tdata[12];
	assign rx_byte     = s_tdata[20:13];

	// architectural registers
	logic [7:0] lcr_q, ier_q, mcr_q, scr_q, dll_q, dlm_q;
	logic [2:0] iir_q;
	logic       dr_q;                    // line status bit 0, data ready
	logic [7:0] lcr_n, ier_n, mcr_n, scr_n, dll_n, dlm_n;
	logic [2:0] iir_n;
	logic       dr_n;

	// output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// FIFO hookup
	logic       rx_push, rx_pop, tx_push, tx_pop;
	logic [7:0] rx_head, tx_head;
	fifo_stat_t rx_stat, tx_stat;

	// result of the current item
	logic [7:0] rd_data;
	logic       irq;
	logic       txv;
	logic [7:0] txb;
	logic       dlab;

	// a result register that is empty or draining frees the input side
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign dlab     = lcr_q[7];

	urb_fifo #(.DEPTH(RX_DEPTH)) u_rx_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rx_push),
		.push_data (rx_byte),
		.pop       (rx_pop),
		.head      (rx_head),
		.stat      (rx_stat)
	);

	urb_fifo #(.DEPTH(TX_DEPTH)) u_tx_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (tx_push),
		.push_data (write_data),
		.pop       (tx_pop),
		.head      (tx_head),
		.stat      (tx_stat)
	);

	// register and FIFO update for one item
	always_comb begin
		lcr_n   = lcr_q;
		ier_n   = ier_q;
		mcr_n   = mcr_q;
		scr_n   = scr_q;
		dll_n   = dll_q;
		dlm_n   = dlm_q;
		iir_n   = iir_q;
		dr_n    = dr_q;
		rd_data = '0;
		irq     = 1'b0;
		txv     = 1'b0;
		txb     = '0;
		rx_push = 1'b0;
		rx_pop  = 1'b0;
		tx_push = 1'b0;
		tx_pop  = 1'b0;
		if (accept) begin
			unique case (act)
				ACT_READ: begin
					if (chip_select) begin
						unique case (reg_offset)
							OFF_RBR: begin
								if (dlab) begin
									rd_data = dll_q;
								end else begin
									if (iir_q == ID_RX) begin
										iir_n = ID_NONE;
									end
									dr_n = 1'b0;      // cleared even with bytes left
									if (!rx_stat.empty) begin
										rd_data = rx_head;
										rx_pop  = 1'b1;
									end
								end
							end
							OFF_IER: rd_data = dlab ? dlm_q : ier_q;
							OFF_IIR: begin
								rd_data = {5'b0, iir_q};
								if (iir_q == ID_TX) begin
									iir_n = ID_NONE;
								end
							end
							OFF_LCR: rd_data = lcr_q;
							OFF_MCR: rd_data = mcr_q;
							OFF_LSR: rd_data = {LSR_FIXED, dr_q};
							OFF_MSR: rd_data = MSR_FIXED;
							default: rd_data = scr_q;
						endcase
					end
				end
				ACT_WRITE: begin
					if (chip_select) begin
						unique case (reg_offset)
							OFF_RBR: begin
								if (dlab) begin
									dll_n = write_data;
								end else begin
									tx_push = 1'b1;    // dropped inside the FIFO when full
									if (ier_q[1]) begin
										iir_n = ID_TX;
										irq   = 1'b1;
									end
								end
							end
							OFF_IER: begin
								if (dlab) begin
									dlm_n = write_data;
								end else begin
									ier_n = write_data;
									if (write_data[1]) begin
										iir_n = ID_TX;
										irq   = 1'b1;
									end
								end
							end
							OFF_LCR: lcr_n = write_data;
							OFF_MCR: mcr_n = write_data;
							OFF_SCR: scr_n = write_data;
							default: ;                  // read-only offsets
						endcase
					end
				end
				ACT_STEP: begin
					if (rx_valid) begin
						rx_push = 1'b1;
						dr_n    = 1'b1;                 // set even if the byte is dropped
						if (ier_q[0]) begin
							iir_n = ID_RX;
							irq   = 1'b1;
						end
					end
					if (!tx_stat.empty) begin
						txv    = 1'b1;
						txb    = tx_head;
						tx_pop = 1'b1;
					end
				end
				default: ;                              // unused action code
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcr_q <= '0;
			ier_q <= '0;
			mcr_q <= '0;
			scr_q <= '0;
			dll_q <= '0;
			dlm_q <= '0;
			iir_q <= ID_NONE;
			dr_q  <= 1'b0;
		end else begin
			lcr_q <= lcr_n;
			ier_q <= ier_n;
			mcr_q <= mcr_n;
			scr_q <= scr_n;
			dll_q <= dll_n;
			dlm_q <= dlm_n;
			iir_q <= iir_n;
			dr_q  <= dr_n;
		end
	end

	// output register: valid under reset, payload plain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {6'b0, txb, txv, irq, rd_data};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// File: src/urb_cell.sv
// One byte cell of the shifting FIFO chain.
// Depends on urb_pkg.
module urb_cell (
	input  logic                      clk,
	input  logic                      shift_en,
	input  logic [urb_pkg::BYTE_W-1:0] nbr_data,
	input  logic                      load_en,
	input  logic [urb_pkg::BYTE_W-1:0] load_data,
	output logic [urb_pkg::BYTE_W-1:0] data_q
);
	import urb_pkg::*;

	// push and pop never fall in the same cycle
	always_ff @(posedge clk) begin
		if (load_en) begin
			data_q <= load_data;
		end else if (shift_en) begin
			data_q <= nbr_data;
		end
	end

endmodule

// File: src/urb_fifo.sv
// FIFO built as a chain of byte cells; head sits in cell 0, a pop shifts the chain.
// Depends on urb_pkg and urb_cell.
module urb_fifo #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [urb_pkg::BYTE_W-1:0] push_data,
	input  logic                       pop,
	output logic [urb_pkg::BYTE_W-1:0] head,
	output urb_pkg::fifo_stat_t        stat
);
	import urb_pkg::*;

	localparam int unsigned NC = DEPTH - 1;           // one slot stays unused
	localparam int unsigned CW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

	logic [CW-1:0]     count_q;
	logic [BYTE_W-1:0] cell_data [NC];
	logic              do_push;
	logic              do_pop;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(NC));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = cell_data[0];

	for (genvar g = 0; g < NC; g++) begin : g_cell
		logic [BYTE_W-1:0] nbr;
		if (g == NC - 1) begin : g_last
			assign nbr = cell_data[g];
		end else begin : g_mid
			assign nbr = cell_data[g+1];
		end
		urb_cell u_cell (
			.clk       (clk),
			.shift_en  (do_pop),
			.nbr_data  (nbr),
			.load_en   (do_push && (count_q == CW'(g))),
			.load_data (push_data),
			.data_q    (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_push) begin
			count_q <= count_q + 1'b1;
		end else if (do_pop) begin
			count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: src/urb_checker.sv
// Port-level checker for the UART register block, bound to the top level.
// Depends on urb_pkg and uart_register_block.
module urb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [urb_pkg::ACT_W-1:0]      s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [urb_pkg::OUT_DATA_W-1:0] m_tdata
);
	import urb_pkg::*;

	// protocol: a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// an empty result register never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// every item other than a read shows up next cycle with zero read data
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != ACT_READ) |=> m_tvalid && (m_tdata[7:0] == 8'h00))
		else $error("read data on a non-read item");

	// reads never raise the interrupt
	a_rd_irq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACT_READ) |=> m_tvalid && !m_tdata[8])
		else $error("interrupt raised by a read");

	// no transmit byte without transmit valid
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[9] |-> (m_tdata[17:10] == 8'h00))
		else $error("tx byte without tx valid");

endmodule

bind uart_register_block urb_checker u_urb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: tb/uart_register_block_test.sv
// Self-checking testbench for uart_register_block: streams bus reads, bus writes and line steps,
// predicts each response from a behavioral copy of the UART registers and FIFOs, and checks it.
// Depends on urb_pkg and the uart_register_block RTL only.
module uart_register_block_test;
	timeunit 1ns;
	timeprecision 1ps;

	import urb_pkg::*;

	localparam int unsigned RX_DEPTH = 16;
	localparam int unsigned TX_DEPTH = 16;
	// one slot of each FIFO stays unused
	localparam int unsigned RX_ROOM = RX_DEPTH - 1;
	localparam int unsigned TX_ROOM = TX_DEPTH - 1;
	// action code the block must treat as a no-op
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [7:0] LSR_RESET = 8'h60;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned RANDOM_ITEMS = 400;

	// s_tdata fields, lowest bits last
	typedef struct packed {
		logic [2:0] pad;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       chip_select;
		logic [7:0] write_data;
		logic [2:0] reg_offset;
	} uart_item_t;

	// m_tdata fields, lowest bits last
	typedef struct packed {
		logic [5:0] pad;
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       irq_pulse;
		logic [7:0] read_data;
	} uart_response_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [ACT_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// predicted UART state
	logic [7:0] reg_lcr = 8'h00;
	logic [7:0] reg_ier = 8'h00;
	logic [2:0] reg_iir = ID_NONE;
	logic [7:0] reg_lsr = LSR_RESET;
	logic [7:0] reg_mcr = 8'h00;
	logic [7:0] reg_scr = 8'h00;
	logic [7:0] reg_dll = 8'h00;
	logic [7:0] reg_dlm = 8'h00;
	logic [7:0] rx_bytes[$];
	logic [7:0] tx_bytes[$];

	uart_response_t pending_responses[$];
	int unsigned error_count = 0;
	int unsigned useful_items = 0;
	int unsigned quiet_cycles = 0;
	// set while neither side may idle
	logic calm = 1'b0;

	uart_register_block #(
		.RX_DEPTH(RX_DEPTH),
		.TX_DEPTH(TX_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Behavioral UART: updates the predicted state and returns the response of one item.
	function automatic uart_response_t compute_response(input logic [ACT_W-1:0] act,
			input uart_item_t it);
		uart_response_t r;
		logic dlab;
		logic tx_side;
		r = '0;
		dlab = reg_lcr[7];
		tx_side = 1'b0;
		case (act)
			ACT_READ: if (it.chip_select) begin
				case (it.reg_offset)
					OFF_RBR: if (dlab) begin
						r.read_data = reg_dll;
					end else begin
						if (reg_iir == ID_RX) reg_iir = ID_NONE;
						// data ready drops even with bytes still queued
						reg_lsr[0] = 1'b0;
						if (rx_bytes.size() != 0) r.read_data = rx_bytes.pop_front();
					end
					OFF_IER: r.read_data = dlab ? reg_dlm : reg_ier;
					OFF_IIR: begin
						r.read_data = {5'd0, reg_iir};
						if (reg_iir == ID_TX) reg_iir = ID_NONE;
					end
					OFF_LCR: r.read_data = reg_lcr;
					OFF_MCR: r.read_data = reg_mcr;
					OFF_LSR: r.read_data = reg_lsr;
					OFF_MSR: r.read_data = MSR_FIXED;
					default: r.read_data = reg_scr;
				endcase
			end
			ACT_WRITE: if (it.chip_select) begin
				case (it.reg_offset)
					OFF_RBR: if (dlab) begin
						reg_dll = it.write_data;
					end else begin
						if (tx_bytes.size() < TX_ROOM) tx_bytes.push_back(it.write_data);
						tx_side = 1'b1;
					end
					OFF_IER: if (dlab) begin
						reg_dlm = it.write_data;
					end else begin
						reg_ier = it.write_data;
						tx_side = 1'b1;
					end
					OFF_LCR: reg_lcr = it.write_data;
					OFF_MCR: reg_mcr = it.write_data;
					OFF_SCR: reg_scr = it.write_data;
					default: ; // read-only offsets
				endcase
				if (tx_side && reg_ier[1]) begin
					reg_iir = ID_TX;
					r.irq_pulse = 1'b1;
				end
			end
			ACT_STEP: begin
				if (it.rx_valid) begin
					// a byte dropped on a full FIFO still sets data ready
					if (rx_bytes.size() < RX_ROOM) rx_bytes.push_back(it.rx_byte);
					reg_lsr[0] = 1'b1;
					if (reg_ier[0]) begin
						reg_iir = ID_RX;
						r.irq_pulse = 1'b1;
					end
				end
				if (tx_bytes.size() != 0) begin
					r.tx_valid = 1'b1;
					r.tx_byte = tx_bytes.pop_front();
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 50) $display("%0t ns: %s", $time, msg);
	endtask

	// Drives one item, waits for its transfer, records the prediction, then maybe idles.
	task automatic send_item(input logic [ACT_W-1:0] act, input uart_item_t it);
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= it;
		do @(posedge clk); while (!s_tready);
		pending_responses.push_back(compute_response(act, it));
		if (act == ACT_STEP || ((act == ACT_READ || act == ACT_WRITE) && it.chip_select))
			useful_items++;
		while (!calm && $urandom_range(0, 99) < 6) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic uart_item_t random_item();
		uart_item_t it;
		it = '0;
		it.reg_offset = 3'($urandom_range(0, 7));
		it.write_data = 8'($urandom_range(0, 255));
		it.chip_select = 1'($urandom_range(0, 1));
		it.rx_valid = 1'($urandom_range(0, 1));
		it.rx_byte = 8'($urandom_range(0, 255));
		return it;
	endfunction

	// Bus accesses and line steps carry random junk in the fields they ignore.
	task automatic do_read(input logic [2:0] off, input logic cs = 1'b1);
		uart_item_t it;
		it = random_item();
		it.reg_offset = off;
		it.chip_select = cs;
		send_item(ACT_READ, it);
	endtask

	task automatic do_write(input logic [2:0] off, input logic [7:0] data,
			input logic cs = 1'b1);
		uart_item_t it;
		it = random_item();
		it.reg_offset = off;
		it.write_data = data;
		it.chip_select = cs;
		send_item(ACT_WRITE, it);
	endtask

	task automatic do_step(input logic rxv, input logic [7:0] rxb);
		uart_item_t it;
		it = random_item();
		it.rx_valid = rxv;
		it.rx_byte = rxb;
		send_item(ACT_STEP, it);
	endtask

	// FIFO traffic needs the divisor latch mapped out.
	task automatic clear_dlab();
		if (reg_lcr[7]) do_write(OFF_LCR, 8'($urandom_range(0, 127)));
	endtask

	// Reset values, unselected accesses and the unused action.
	task automatic test_reset_values();
		uart_item_t it;
		do_read(OFF_RBR);              // empty receive FIFO reads 0
		do_read(OFF_IIR);
		do_read(OFF_LSR);
		do_read(OFF_MSR);
		do_read(OFF_LSR, 1'b0);
		do_write(OFF_SCR, 8'hFF, 1'b0);
		it = random_item();
		it.chip_select = 1'b1;
		it.rx_valid = 1'b1;
		send_item(ACT_UNUSED, it);
	endtask

	// Divisor latch mapping and writes to read-only offsets.
	task automatic test_register_map();
		do_write(OFF_LCR, 8'h80);
		do_write(OFF_RBR, 8'hFF);
		do_write(OFF_IER, 8'h00);
		do_read(OFF_RBR);
		do_read(OFF_IER);
		do_write(OFF_LCR, 8'h7F);
		do_write(OFF_IIR, 8'hFF);
		do_write(OFF_LSR, 8'hFF);
		do_write(OFF_MSR, 8'hFF);
		do_read(OFF_LCR);
	endtask

	// Transmit and receive interrupts, data ready, and the FIFO round trip.
	task automatic test_interrupts();
		do_write(OFF_IER, 8'h03);      // raises the transmit interrupt
		do_read(OFF_IIR);              // clears it
		do_write(OFF_RBR, 8'h00);
		do_step(1'b1, 8'hFF);
		do_step(1'b1, 8'h00);
		do_read(OFF_IIR);
		do_read(OFF_RBR);              // data ready drops with a byte left
		do_read(OFF_LSR);
		do_read(OFF_RBR);
		do_read(OFF_RBR);
		do_write(OFF_IER, 8'h00);
	endtask

	// Sender holds off until every response has drained.
	task automatic test_sender_pause();
		clear_dlab();
		repeat (5) do_write(OFF_RBR, 8'($urandom_range(0, 255)));
		repeat (3) do_step(1'b1, 8'($urandom_range(0, 255)));
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_responses.size() != 0);
		do_step(1'b0, 8'h00);
	endtask

	// Bursts that fill and drain both FIFOs, register pokes, noise and pauses.
	task automatic test_random_traffic(input int unsigned quota);
		int unsigned goal, kind, burst, left;
		logic [7:0] data;
		goal = useful_items + quota;
		while (useful_items < goal) begin
			left = goal - useful_items;
			calm = (left <= 250) && (left > 150);
			kind = $urandom_range(0, 19);
			burst = $urandom_range(1, 20);
			if (kind < 4) begin
				clear_dlab();
				repeat (burst) do_step($urandom_range(0, 9) != 0, 8'($urandom_range(0, 255)));
			end else if (kind < 8) begin
				clear_dlab();
				repeat (burst) do_write(OFF_RBR, 8'($urandom_range(0, 255)));
			end else if (kind < 12) begin
				clear_dlab();
				repeat (burst) begin
					case ($urandom_range(0, 5))
						0, 1, 2: do_read(OFF_RBR);
						3: do_read(OFF_IIR);
						4: do_read(OFF_LSR);
						default: do_step(1'b0, 8'($urandom_range(0, 255)));
					endcase
				end
			end else if (kind < 17) begin
				repeat (burst) begin
					case ($urandom_range(0, 3))
						0: data = 8'h00;
						1: data = 8'hFF;
						default: data = 8'($urandom_range(0, 255));
					endcase
					if ($urandom_range(0, 1)) do_write(3'($urandom_range(0, 7)), data);
					else do_read(3'($urandom_range(0, 7)));
				end
			end else if (kind < 19) begin
				repeat (burst) send_item(2'($urandom_range(0, 3)), random_item());
			end else begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending_responses.size() != 0);
				do_step(1'b0, 8'h00);
			end
		end
		calm = 1'b0;
	endtask

	// Receiver stalls at random, except in the calm stretch.
	always @(posedge clk) m_tready <= calm || ($urandom_range(0, 99) >= 6);

	// Every response transfer is matched against the oldest prediction.
	always @(posedge clk) begin
		uart_response_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_responses.size() == 0) begin
				report_mismatch($sformatf("response %h with none pending", got));
			end else begin
				want = pending_responses.pop_front();
				if (got.read_data !== want.read_data)
					report_mismatch($sformatf("read_data got %h want %h",
						got.read_data, want.read_data));
				if (got.irq_pulse !== want.irq_pulse)
					report_mismatch($sformatf("irq_pulse got %b want %b",
						got.irq_pulse, want.irq_pulse));
				if (got.tx_valid !== want.tx_valid)
					report_mismatch($sformatf("tx_valid got %b want %b",
						got.tx_valid, want.tx_valid));
				if (got.tx_byte !== want.tx_byte)
					report_mismatch($sformatf("tx_byte got %h want %h",
						got.tx_byte, want.tx_byte));
			end
		end
	end

	// Ends a hung run: counts cycles without any transfer on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_register_map();
		test_interrupts();
		test_sender_pause();
		test_random_traffic(RANDOM_ITEMS);
		s_tvalid <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
		// wait on to catch any stray responses
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
